// ===== rtl/mgd_pkg.sv =====
package mgd_pkg;

    localparam int SMELL_W     = 24;
    localparam int GAIN_W      = 16;
    localparam int DIM_W       = 9;
    localparam int N_W         = 4;
    localparam int TAPS        = 9;
    localparam int TAP_W       = $clog2(TAPS);
    localparam int CENTRE_TAP  = 4;
    localparam int MID_NEW_TAP = 7;
    localparam int SUM_W       = SMELL_W + N_W;
    localparam int PSUM_W      = SUM_W + GAIN_W;
    localparam int PKEEP_W     = SMELL_W + GAIN_W;
    localparam int PKEEPN_W    = PKEEP_W + N_W;
    localparam int ACC_W       = PKEEPN_W + 2;
    localparam int QUO_W       = ACC_W - GAIN_W;
    localparam int GRID_MIN    = 3;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_GAIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_GAIN      = 8'd3;

    localparam logic [DIM_W-1:0]  GRID_WIDTH_RST     = 9'd256;
    localparam logic [DIM_W-1:0]  GRID_HEIGHT_RST    = 9'd256;
    localparam logic [GAIN_W-1:0] NEIGHBOUR_GAIN_RST = 16'd13107;
    localparam logic [GAIN_W-1:0] KEEP_GAIN_RST      = 16'd51773;

    localparam logic ACT_CELL  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic [TAPS-1:0][SMELL_W-1:0] smell;
        logic [TAPS-1:0]              solid;
    } mgd_win_t;

    typedef struct packed {
        logic [SMELL_W-1:0] top_smell;
        logic [SMELL_W-1:0] mid_smell;
        logic               top_solid;
        logic               mid_solid;
    } mgd_line_t;

endpackage

// ===== rtl/mgd_line_mem.sv =====
module mgd_line_mem import mgd_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output mgd_line_t                rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  mgd_line_t                wr_data
);

    mgd_line_t line_mem [DEPTH];
    mgd_line_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mgd_div.sv =====
module mgd_div import mgd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [N_W-1:0]   divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [N_W-1:0]   rem_reg;
    logic [N_W:0]     trial;
    logic [N_W:0]     diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                rem_reg <= fits ? diff[N_W-1:0] : trial[N_W-1:0];
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/mgd_mean_unit.sv =====
module mgd_mean_unit import mgd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  mgd_win_t           win,
    input  logic [GAIN_W-1:0]  neighbour_gain,
    input  logic [GAIN_W-1:0]  keep_gain,
    output logic               done,
    output logic [SMELL_W-1:0] result
);

    typedef enum logic [2:0] {
        M_IDLE, M_SUM, M_MUL, M_SCALE, M_ADD, M_DIV
    } mean_state_t;

    mean_state_t          state_reg;
    logic [TAP_W-1:0]     idx_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [N_W-1:0]       n_reg;
    logic [PSUM_W-1:0]    psum_reg;
    logic [PKEEP_W-1:0]   pkeep_reg;
    logic [PKEEPN_W-1:0]  pkeepn_reg;
    logic [QUO_W-1:0]     quo_in_reg;
    logic                 div_start_reg;
    logic                 done_reg;
    logic [SMELL_W-1:0]   result_reg;
    logic                 div_done;
    logic [QUO_W-1:0]     div_quo;
    logic [ACC_W-1:0]     acc;

    assign acc = ACC_W'(psum_reg) + ACC_W'(pkeepn_reg) + (ACC_W'(n_reg) << (GAIN_W - 1));

    mgd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (quo_in_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= M_IDLE;
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        sum_reg   <= '0;
                        n_reg     <= '0;
                        idx_reg   <= '0;
                        state_reg <= M_SUM;
                    end
                end
                M_SUM: begin
                    if (!win.solid[idx_reg]) begin
                        sum_reg <= sum_reg + SUM_W'(win.smell[idx_reg]);
                        n_reg   <= n_reg + N_W'(1);
                    end
                    if (idx_reg == TAP_W'(TAPS - 1)) begin
                        state_reg <= M_MUL;
                    end else begin
                        idx_reg <= idx_reg + TAP_W'(1);
                    end
                end
                M_MUL: begin
                    psum_reg  <= sum_reg * neighbour_gain;
                    pkeep_reg <= win.smell[CENTRE_TAP] * keep_gain;
                    state_reg <= M_SCALE;
                end
                M_SCALE: begin
                    pkeepn_reg <= pkeep_reg * n_reg;
                    state_reg  <= M_ADD;
                end
                M_ADD: begin
                    quo_in_reg    <= acc[ACC_W-1:GAIN_W];
                    div_start_reg <= 1'b1;
                    state_reg     <= M_DIV;
                end
                M_DIV: begin
                    if (div_done) begin
                        result_reg <= (|div_quo[QUO_W-1:SMELL_W]) ? '1 : div_quo[SMELL_W-1:0];
                        done_reg   <= 1'b1;
                        state_reg  <= M_IDLE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/masked_grid_diffusion_step_unit.sv =====
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | tuser: action; tdata: smell_in, solid
// m_      | out       | m_tvalid/m_tready  | tdata: smell_out; tlast: last_cell
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
// A cell request passes through ST_CELL, and also through ST_OUT when it passes a result through.
// A diffused cell adds ST_CALC: a serial sum over the nine window taps and a
// one-bit-per-cycle divider by the count of open taps. Flush requests pass through ST_OUT, some via ST_FLUSH.
// Line buffer reads come from the registered output of the synchronous memory port.
// Reset is synchronous on aresetn low; line buffer contents are not cleared.
// A result waiting on m_tready holds the next result back, not the next request.
module masked_grid_diffusion_step_unit import mgd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // smell_in [23:0], solid [24]
    input  logic                  s_tuser,   // action [0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // smell_out [23:0]
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int TW = DW + HW;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CELL, ST_FLUSH, ST_CALC, ST_OUT
    } top_state_t;

    top_state_t         state_reg;
    logic [DIM_W-1:0]   grid_width_reg;
    logic [DIM_W-1:0]   grid_height_reg;
    logic [GAIN_W-1:0]  neighbour_gain_reg;
    logic [GAIN_W-1:0]  keep_gain_reg;
    logic [AW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic               input_done_reg;
    logic [TW-1:0]      emitted_reg;
    mgd_win_t           win_reg;
    logic [SMELL_W-1:0] smell_hold_reg;
    logic               solid_hold_reg;
    logic [SMELL_W-1:0] res_reg;
    logic               last_reg;
    logic               start_reg;
    logic               m_tvalid_reg;
    logic [SMELL_W-1:0] m_tdata_reg;
    logic               m_tlast_reg;

    logic [DW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic [TW-1:0]      total;
    logic [TW-1:0]      flush_col_full;
    logic [AW-1:0]      rd_addr;
    logic [DW-1:0]      col_inc;
    logic [HW-1:0]      row_inc;
    logic               cell_ok;
    logic               flush_ok;
    logic               use_win;
    logic               emit;
    logic               diffuse;
    mgd_line_t          rd_line;
    mgd_line_t          wr_line;
    logic               mean_done;
    logic [SMELL_W-1:0] mean_result;

    always_comb begin
        if (grid_width_reg < DIM_W'(GRID_MIN)) begin
            w_eff = DW'(GRID_MIN);
        end else if (32'(grid_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(grid_width_reg);
        end
        if (grid_height_reg < DIM_W'(GRID_MIN)) begin
            h_eff = HW'(GRID_MIN);
        end else if (32'(grid_height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(grid_height_reg);
        end
    end

    assign total          = TW'(w_eff) * TW'(h_eff);
    assign flush_col_full = emitted_reg - (total - TW'(w_eff));
    assign use_win        = emitted_reg <= (total - TW'(w_eff) - TW'(1));
    assign cell_ok        = !input_done_reg && (DW'(col_reg) < w_eff) && (HW'(row_reg) < h_eff);
    assign flush_ok       = input_done_reg && (emitted_reg < total);
    assign col_inc        = DW'(col_reg) + DW'(1);
    assign row_inc        = HW'(row_reg) + HW'(1);
    assign emit           = ((row_reg != '0) && (col_reg != '0)) || (row_reg > RW'(1));
    assign diffuse        = emit && (row_reg > RW'(1)) && (col_reg > AW'(1))
                            && !win_reg.solid[MID_NEW_TAP];
    assign rd_addr        = (s_tuser == ACT_FLUSH) ? flush_col_full[AW-1:0] : col_reg;

    assign wr_line.top_smell = rd_line.mid_smell;
    assign wr_line.mid_smell = smell_hold_reg;
    assign wr_line.top_solid = rd_line.mid_solid;
    assign wr_line.mid_solid = solid_hold_reg;

    mgd_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (state_reg == ST_IDLE),
        .rd_addr (rd_addr),
        .rd_data (rd_line),
        .wr_en   (state_reg == ST_CELL),
        .wr_addr (col_reg),
        .wr_data (wr_line)
    );

    mgd_mean_unit u_mean (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (start_reg),
        .win            (win_reg),
        .neighbour_gain (neighbour_gain_reg),
        .keep_gain      (keep_gain_reg),
        .done           (mean_done),
        .result         (mean_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            grid_width_reg     <= GRID_WIDTH_RST;
            grid_height_reg    <= GRID_HEIGHT_RST;
            neighbour_gain_reg <= NEIGHBOUR_GAIN_RST;
            keep_gain_reg      <= KEEP_GAIN_RST;
            col_reg            <= '0;
            row_reg            <= '0;
            input_done_reg     <= 1'b0;
            emitted_reg        <= '0;
            win_reg            <= '0;
            start_reg          <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == ACT_CELL) begin
                            if (cell_ok) begin
                                smell_hold_reg <= s_tdata[SMELL_W-1:0];
                                solid_hold_reg <= s_tdata[SMELL_W];
                                state_reg      <= ST_CELL;
                            end
                        end else if (flush_ok) begin
                            last_reg    <= (emitted_reg == (total - TW'(1)));
                            emitted_reg <= emitted_reg + TW'(1);
                            if ((emitted_reg + TW'(1)) == total) begin
                                // drain complete: start a new grid
                                col_reg        <= '0;
                                row_reg        <= '0;
                                input_done_reg <= 1'b0;
                                emitted_reg    <= '0;
                                win_reg        <= '0;
                            end
                            if (use_win) begin
                                res_reg   <= win_reg.smell[MID_NEW_TAP];
                                state_reg <= ST_OUT;
                            end else begin
                                state_reg <= ST_FLUSH;
                            end
                        end
                    end
                end
                ST_CELL: begin
                    win_reg.smell <= {smell_hold_reg, rd_line.mid_smell, rd_line.top_smell,
                                      win_reg.smell[TAPS-1:3]};
                    win_reg.solid <= {solid_hold_reg, rd_line.mid_solid, rd_line.top_solid,
                                      win_reg.solid[TAPS-1:3]};
                    if (col_inc == w_eff) begin
                        col_reg <= '0;
                        if (row_inc == h_eff) begin
                            row_reg        <= '0;
                            input_done_reg <= 1'b1;
                        end else begin
                            row_reg <= row_inc[RW-1:0];
                        end
                    end else begin
                        col_reg <= col_inc[AW-1:0];
                    end
                    last_reg <= 1'b0;
                    if (emit) begin
                        emitted_reg <= emitted_reg + TW'(1);
                        if (diffuse) begin
                            start_reg <= 1'b1;
                            state_reg <= ST_CALC;
                        end else begin
                            res_reg   <= win_reg.smell[MID_NEW_TAP];
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FLUSH: begin
                    res_reg   <= rd_line.mid_smell;
                    state_reg <= ST_OUT;
                end
                ST_CALC: begin
                    if (mean_done) begin
                        res_reg   <= mean_result;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_reg;
                        m_tlast_reg  <= last_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_GRID_WIDTH, REG_GRID_HEIGHT: begin
                        if (cfg_index == REG_GRID_WIDTH) begin
                            grid_width_reg <= cfg_data[DIM_W-1:0];
                        end else begin
                            grid_height_reg <= cfg_data[DIM_W-1:0];
                        end
                        col_reg        <= '0;
                        row_reg        <= '0;
                        input_done_reg <= 1'b0;
                        emitted_reg    <= '0;
                        win_reg        <= '0;
                    end
                    REG_NEIGHBOUR_GAIN: neighbour_gain_reg <= cfg_data;
                    REG_KEEP_GAIN:      keep_gain_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import mgd_pkg::*;

    localparam int LINE_MAX      = DEF_MAX_WIDTH;
    localparam int ROWS_MAX      = DEF_MAX_HEIGHT;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SHOW_LIMIT    = 10;
    localparam logic [SMELL_W-1:0] SMELL_MAX = '1;

    typedef struct packed {
        logic [SMELL_W-1:0] smell;
        logic               last;
    } cell_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = ACT_CELL;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    masked_grid_diffusion_step_unit #(
        .MAX_WIDTH (LINE_MAX),
        .MAX_HEIGHT(ROWS_MAX)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // diffusion model state
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [GAIN_W-1:0]  spread_weight;
    logic [GAIN_W-1:0]  keep_weight;
    logic [SMELL_W-1:0] line_smell [2*LINE_MAX];
    logic               line_solid [2*LINE_MAX];
    logic [SMELL_W-1:0] win_smell  [TAPS];
    logic [TAPS-1:0]    win_solid;
    int                 cell_col;
    int                 cell_row;
    int                 results_issued;
    bit                 grid_loaded;
    cell_result_t       pending_cells[$];

    int unsigned cycle_count    = 0;
    int          burst_left     = 0;
    int          requests_sent  = 0;
    int          requests_taken = 0;
    int          results_seen   = 0;
    int          grids_run      = 0;
    int          fail_count     = 0;
    int          shown_count    = 0;
    int          stall_mode     = 0;
    int          stall_span     = 0;
    int          stall_beat     = 0;

    function automatic int used_width();
        return width_reg < GRID_MIN ? GRID_MIN : (width_reg > LINE_MAX ? LINE_MAX : width_reg);
    endfunction

    function automatic int used_height();
        return height_reg < GRID_MIN ? GRID_MIN : (height_reg > ROWS_MAX ? ROWS_MAX : height_reg);
    endfunction

    function automatic void rewind_grid();
        for (int i = 0; i < TAPS; i++) win_smell[i] = '0;
        win_solid      = '0;
        cell_col       = 0;
        cell_row       = 0;
        results_issued = 0;
        grid_loaded    = 1'b0;
    endfunction

    function automatic logic [SMELL_W-1:0] blend_window();
        longint unsigned sum, n, num, q;
        sum = 0;
        n   = 0;
        for (int i = 0; i < TAPS; i++) begin
            if (!win_solid[i]) begin
                sum += win_smell[i];
                n++;
            end
        end
        if (n == 0) return win_smell[CENTRE_TAP];
        num = sum * spread_weight + win_smell[CENTRE_TAP] * keep_weight * n;
        q   = (num + n * 32768) / (n * 65536);
        return (q > SMELL_MAX) ? SMELL_MAX : q[SMELL_W-1:0];
    endfunction

    function automatic bit predict_request(input logic act, input logic [SMELL_W-1:0] smell,
                                           input logic sol);
        int w, h, total, c, r, col, orow, ocol;
        logic [SMELL_W-1:0] top, mid, prev_mid, val;
        logic tops, mids;
        bit emit, interior;
        cell_result_t res;
        w     = used_width();
        h     = used_height();
        total = w * h;
        val   = '0;
        emit  = 1'b0;
        if (act == ACT_CELL) begin
            c = cell_col;
            r = cell_row;
            if (grid_loaded || c >= w || r >= h) return 1'b0;
            prev_mid = win_smell[MID_NEW_TAP];
            top  = line_smell[c];
            mid  = line_smell[LINE_MAX + c];
            tops = line_solid[c];
            mids = line_solid[LINE_MAX + c];
            line_smell[c]            = mid;
            line_solid[c]            = mids;
            line_smell[LINE_MAX + c] = smell;
            line_solid[LINE_MAX + c] = sol;
            for (int i = 0; i < 6; i++) win_smell[i] = win_smell[i + 3];
            win_smell[6] = top;
            win_smell[7] = mid;
            win_smell[8] = smell;
            win_solid    = {sol, mids, tops, win_solid[TAPS-1:3]};
            if ((r >= 1 && c >= 1) || r >= 2) begin
                emit = 1'b1;
                if (c == 0) begin
                    val = prev_mid;
                end else begin
                    orow = r - 1;
                    ocol = c - 1;
                    interior = orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2;
                    if (interior && !win_solid[CENTRE_TAP]) val = blend_window();
                    else val = win_smell[CENTRE_TAP];
                end
            end
            c++;
            if (c == w) begin
                c = 0;
                r++;
                if (r == h) begin
                    r = 0;
                    grid_loaded = 1'b1;
                end
            end
            cell_col = c;
            cell_row = r;
            if (emit) begin
                res.smell = val;
                res.last  = 1'b0;
                pending_cells.push_back(res);
                results_issued++;
            end
            return 1'b1;
        end
        if (!grid_loaded || results_issued >= total) return 1'b0;
        if (results_issued <= total - w - 1) begin
            val = win_smell[MID_NEW_TAP];
        end else begin
            col = results_issued - (total - w);
            val = (col < w) ? line_smell[LINE_MAX + col] : '0;
        end
        res.smell = val;
        res.last  = (results_issued == total - 1);
        pending_cells.push_back(res);
        results_issued++;
        if (results_issued >= total) rewind_grid();
        return 1'b1;
    endfunction

    function automatic logic [SMELL_W-1:0] random_smell();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SMELL_MAX;
            2: return SMELL_W'($urandom_range(0, 255));
            3: return SMELL_MAX - SMELL_W'($urandom_range(0, 255));
            default: return SMELL_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return NEIGHBOUR_GAIN_RST;
            3: return KEEP_GAIN_RST;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim(input int hi);
        case ($urandom_range(0, 9))
            0: return CFG_DATA_W'($urandom_range(0, GRID_MIN - 1));
            1: return {7'($urandom), DIM_W'($urandom_range(GRID_MIN, hi))};
            2: return CFG_DATA_W'($urandom_range(9, 20));
            default: return CFG_DATA_W'($urandom_range(GRID_MIN, hi));
        endcase
    endfunction

    task automatic send_request(input logic act, input logic [SMELL_W-1:0] smell,
                                input logic sol);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - SMELL_W - 1){1'b0}}, sol, smell};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        requests_sent++;
        if (predict_request(act, smell, sol)) requests_taken++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_WIDTH: begin
                width_reg = data[DIM_W-1:0];
                rewind_grid();
            end
            REG_GRID_HEIGHT: begin
                height_reg = data[DIM_W-1:0];
                rewind_grid();
            end
            REG_NEIGHBOUR_GAIN: spread_weight = data;
            REG_KEEP_GAIN:      keep_weight = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic stream_grid(input int cell_count, input int noise_pct, input int solid_pct);
        int w, total;
        w     = used_width();
        total = w * used_height();
        for (int k = 0; k < cell_count; k++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_request(ACT_FLUSH, random_smell(), 1'($urandom));
            send_request(ACT_CELL, random_smell(), $urandom_range(0, 99) < solid_pct);
        end
        if (cell_count >= total) begin
            for (int k = 0; k <= w; k++) begin
                if ($urandom_range(0, 99) < noise_pct)
                    send_request(ACT_CELL, random_smell(), 1'($urandom));
                send_request(ACT_FLUSH, random_smell(), 1'($urandom));
            end
            if ($urandom_range(0, 99) < noise_pct)
                send_request(ACT_FLUSH, random_smell(), 1'($urandom));
        end
        grids_run++;
    endtask

    task automatic test_default_gains();
        logic [SMELL_W-1:0] vals [9] = '{24'h000000, 24'hFFFFFF, 24'h000001,
                                         24'h123456, 24'hFFFFFF, 24'h000000,
                                         24'hABCDEF, 24'h800000, 24'h7FFFFF};
        logic [8:0] walls = 9'b0_1010_1000;
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(GRID_MIN));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(GRID_MIN));
        // early drain request on an incomplete grid
        send_request(ACT_FLUSH, SMELL_MAX, 1'b1);
        for (int k = 0; k < 9; k++) send_request(ACT_CELL, vals[k], walls[k]);
        // cell on a full grid, then drain, then one drain too many
        send_request(ACT_CELL, SMELL_MAX, 1'b0);
        repeat (GRID_MIN + 1) send_request(ACT_FLUSH, '0, 1'b0);
        send_request(ACT_FLUSH, '0, 1'b0);
        settle();
        grids_run++;
    endtask

    task automatic test_saturation();
        write_reg(REG_NEIGHBOUR_GAIN, '1);
        write_reg(REG_KEEP_GAIN, '1);
        for (int k = 0; k < 9; k++) send_request(ACT_CELL, SMELL_MAX, k == 2);
        repeat (GRID_MIN + 1) send_request(ACT_FLUSH, SMELL_MAX, 1'b1);
        settle();
        grids_run++;
    endtask

    task automatic test_size_extremes();
        write_reg(REG_GRID_WIDTH, 16'hFFFF);
        write_reg(REG_GRID_HEIGHT, 16'd2);
        stream_grid(used_width() * used_height(), 5, 20);
        settle();
        write_reg(REG_GRID_WIDTH, 16'd0);
        write_reg(REG_GRID_HEIGHT, 16'hFFFF);
        write_reg(REG_NEIGHBOUR_GAIN, NEIGHBOUR_GAIN_RST);
        write_reg(REG_KEEP_GAIN, '0);
        stream_grid(used_width() * used_height(), 5, 30);
        settle();
    endtask

    task automatic test_random_grids();
        int start, cells, total, noise, solid;
        bit resize;
        start  = requests_taken;
        resize = 1'b1;
        while (requests_taken - start < RANDOM_ITEMS) begin
            if (resize || $urandom_range(0, 3) == 0) begin
                write_reg(REG_GRID_WIDTH, pick_dim(7));
                write_reg(REG_GRID_HEIGHT, pick_dim(6));
                resize = 1'b0;
            end
            if ($urandom_range(0, 2) == 0) write_reg(REG_NEIGHBOUR_GAIN, pick_gain());
            if ($urandom_range(0, 2) == 0) write_reg(REG_KEEP_GAIN, pick_gain());
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_KEEP_GAIN + 1, 255)), CFG_DATA_W'($urandom));
            total = used_width() * used_height();
            cells = total;
            if ($urandom_range(0, 9) == 0) begin
                cells  = $urandom_range(1, total - 1);
                resize = 1'b1;
            end
            noise = ($urandom_range(0, 4) < 3) ? 0 : $urandom_range(3, 15);
            case ($urandom_range(0, 5))
                0: solid = 0;
                1: solid = 100;
                2: solid = 60;
                3: solid = 30;
                default: solid = 10;
            endcase
            stream_grid(cells, noise, solid);
            settle();
        end
    endtask

    always @(posedge aclk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 160);
        end
        stall_span--;
        stall_beat++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom);
            2: m_tready <= (stall_beat % 4) != 0;
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin : check_results
        cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cells.size() == 0) begin
                fail_count++;
                if (shown_count < SHOW_LIMIT) begin
                    $display("unexpected result: smell %h last %b", m_tdata, m_tlast);
                    shown_count++;
                end
            end else begin
                want = pending_cells.pop_front();
                results_seen++;
                if (m_tdata !== want.smell || m_tlast !== want.last) begin
                    fail_count++;
                    if (shown_count < SHOW_LIMIT) begin
                        $display("mismatch at result %0d: smell exp %h got %h, last exp %b got %b",
                                 results_seen, want.smell, m_tdata, want.last, m_tlast);
                        shown_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_cells.size());
        $display("status: fail");
        $finish;
    end

    initial begin : main_sequence
        width_reg     = GRID_WIDTH_RST;
        height_reg    = GRID_HEIGHT_RST;
        spread_weight = NEIGHBOUR_GAIN_RST;
        keep_weight   = KEEP_GAIN_RST;
        for (int i = 0; i < 2 * LINE_MAX; i++) begin
            line_smell[i] = '0;
            line_solid[i] = 1'b0;
        end
        rewind_grid();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_gains();
        test_saturation();
        test_size_extremes();
        test_random_grids();
        settle();
        $display("ran %0d grids: %0d requests sent, %0d left without effect, %0d results checked",
                 grids_run, requests_sent, requests_sent - requests_taken, results_seen);
        $display("sizes from 3x3 to 256-wide and 256-tall, gains at both ends, %0d failures",
                 fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== masked_grid_diffusion_step_unit.f =====
rtl/mgd_pkg.sv
rtl/mgd_line_mem.sv
rtl/mgd_div.sv
rtl/mgd_mean_unit.sv
rtl/masked_grid_diffusion_step_unit.sv
tb/sv/testbench.sv
